// File: src/tprcd_pkg.sv
package tprcd_pkg;

    typedef enum logic [1:0] {
        OP_REPORT_BYTE = 2'd0,
        OP_KEY_PRESS   = 2'd1,
        OP_SET_ENABLE  = 2'd2,
        OP_QUERY       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CONTACT = 2'd0,
        KIND_BAD_ID  = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    // configuration register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_REPORT_ID  = 2'd0;
    localparam logic [1:0] REG_QUIET_TIME = 2'd1;
    localparam logic [1:0] REG_MAX_Y      = 2'd2;

    localparam logic [7:0] ID_SILENT  = 8'hFF;
    localparam int         INFO_SHIFT = 3;
    localparam int         REC_BYTES  = 3;

    localparam logic [7:0]  RST_REPORT_ID = 8'd93;
    localparam logic [63:0] RST_QUIET     = 64'd0;
    localparam logic [11:0] RST_MAX_Y     = 12'd4095;

    typedef struct packed {
        logic [2:0]  slot;
        logic        contact_valid;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        button;
        logic [2:0]  finger_count;
        logic        touch_enabled;
        kind_t       kind;
        logic        last_result;
    } result_t;

endpackage

// File: src/touchpad_report_contact_decoder.sv
// channel  dir  tvalid/tready  tlast        tuser          tdata
// s_       in   transfer       last_byte    operation      data_byte, now_time, key_time, enable
// m_       out  transfer       last_result  result_kind    slot, contact_valid, pos_x, pos_y,
//                                                          button, finger_count, touch_enabled
// apb      cfg  psel/penable   -            -              report_id_match, quiet_time_ns, max_y
//
// report bytes, key presses and enable writes are taken while results are still
// going out. a closing byte or a query waits until the previous report's results
// have left the slot sequencer, one slot per cycle. a touch report gives its five
// results in slot order; the first passes the job registers, the read stage and
// the output register after the closing byte, paced by the held-position memory
// read and the output register. synchronous active-low reset; held positions use
// per-entry valid bits, so no clearing pass. a stalled m_ side holds the sequencer in place.
module touchpad_report_contact_decoder #(
    parameter int REPORT_LEN    = 34,
    parameter int MAX_FINGERS   = 5,
    parameter int FINGER_BYTES  = 5,
    parameter int ID_OFFSET     = 2,
    parameter int INFO_OFFSET   = 3,
    parameter int FINGER_OFFSET = 4
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    // [7:0] data_byte, [71:8] now_time, [135:72] key_time, [136] enable, [143:137] zero
    input  logic [143:0]  s_tdata,
    // [1:0] operation
    input  logic [1:0]    s_tuser,
    input  logic          s_tlast,

    output logic          m_tvalid,
    input  logic          m_tready,
    // [2:0] slot, [3] contact_valid, [15:4] pos_x, [27:16] pos_y, [28] button,
    // [31:29] finger_count, [32] touch_enabled, [39:33] zero
    output logic [39:0]   m_tdata,
    // [1:0] result_kind
    output logic [1:0]    m_tuser,
    output logic          m_tlast,

    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import tprcd_pkg::*;

    localparam int CNT_W = $clog2(REPORT_LEN + 1);
    localparam int IDX_W = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FINGERS - 1);

    // configuration
    logic [7:0]  report_id_reg;
    logic [63:0] quiet_reg;
    logic [11:0] max_y_reg;

    // input side state
    logic [CNT_W-1:0] byte_count_reg;
    logic [7:0]       id_cap_reg;
    logic [7:0]       info_cap_reg;
    logic [7:0]       rec_cap_reg [MAX_FINGERS][REC_BYTES];
    logic             touch_disabled_reg;
    logic [63:0]      last_key_reg;

    // slot sequencer
    logic             job_active_reg;
    kind_t            job_kind_reg;
    logic             job_en_reg;
    logic [7:0]       job_info_reg;
    logic [2:0]       job_cnt_reg;
    logic [7:0]       job_rec_reg [MAX_FINGERS][REC_BYTES];
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] rec_reg;

    // read stage and held-position memory
    logic             s1_valid_reg;
    result_t          s1_reg;
    logic [23:0]      held_mem [MAX_FINGERS];
    logic [MAX_FINGERS-1:0] held_vld_reg;
    logic [23:0]      held_q_reg;
    logic             held_q_vld_reg;
    logic             fwd_hit_reg;
    logic [23:0]      fwd_data_reg;

    // output register
    logic             m_valid_reg;
    result_t          m_res_reg;

    // input decode
    op_t         op;
    logic [7:0]  s_data;
    logic [63:0] s_now;
    logic [63:0] s_key;
    logic        s_enable;
    logic        s_acc;
    logic        store;
    logic [7:0]  id_fin;
    logic [7:0]  info_fin;
    logic [7:0]  rec_fin [MAX_FINGERS][REC_BYTES];
    logic [2:0]  cnt_fin;
    logic [63:0] elapsed;
    logic        quiet;
    logic        new_job;
    kind_t       new_kind;

    assign op       = op_t'(s_tuser);
    assign s_data   = s_tdata[7:0];
    assign s_now    = s_tdata[71:8];
    assign s_key    = s_tdata[135:72];
    assign s_enable = s_tdata[136];

    assign s_tready = !job_active_reg || !(op == OP_QUERY || (op == OP_REPORT_BYTE && s_tlast));
    assign s_acc    = s_tvalid && s_tready;
    assign store    = s_acc && op == OP_REPORT_BYTE && int'(byte_count_reg) < REPORT_LEN;

    // bytes of the report as they stand once the current byte is in
    always_comb begin
        id_fin   = (store && int'(byte_count_reg) == ID_OFFSET) ? s_data : id_cap_reg;
        info_fin = (store && int'(byte_count_reg) == INFO_OFFSET) ? s_data : info_cap_reg;
        for (int k = 0; k < MAX_FINGERS; k++) begin
            for (int b = 0; b < REC_BYTES; b++) begin
                rec_fin[k][b] = (store && int'(byte_count_reg) ==
                                 FINGER_OFFSET + k * FINGER_BYTES + b) ? s_data
                                                                       : rec_cap_reg[k][b];
            end
        end
        cnt_fin = 3'd0;
        for (int i = 0; i < MAX_FINGERS; i++) begin
            cnt_fin = cnt_fin + {2'b00, info_fin[INFO_SHIFT + i]};
        end
    end

    assign elapsed = s_now - last_key_reg;
    assign quiet   = elapsed < quiet_reg;

    always_comb begin
        new_job  = 1'b0;
        new_kind = KIND_CONTACT;
        case (op)
            OP_REPORT_BYTE: begin
                if (s_tlast) begin
                    if (id_fin != report_id_reg) begin
                        if (id_fin != ID_SILENT) begin
                            new_job  = 1'b1;
                            new_kind = KIND_BAD_ID;
                        end
                    end else if (!touch_disabled_reg && !quiet) begin
                        new_job = 1'b1;
                    end
                end
            end
            OP_QUERY: begin
                new_job  = 1'b1;
                new_kind = KIND_STATUS;
            end
            default: begin
                new_job = 1'b0;
            end
        endcase
    end

    // input side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            id_cap_reg         <= '0;
            info_cap_reg       <= '0;
            rec_cap_reg        <= '{default: '0};
            touch_disabled_reg <= 1'b0;
            last_key_reg       <= '0;
        end else if (s_acc) begin
            case (op)
                OP_REPORT_BYTE: begin
                    if (s_tlast) begin
                        byte_count_reg <= '0;
                        id_cap_reg     <= '0;
                        info_cap_reg   <= '0;
                        rec_cap_reg    <= '{default: '0};
                    end else begin
                        if (store) begin
                            byte_count_reg <= byte_count_reg + 1'b1;
                        end
                        id_cap_reg   <= id_fin;
                        info_cap_reg <= info_fin;
                        rec_cap_reg  <= rec_fin;
                    end
                end
                OP_KEY_PRESS:  last_key_reg       <= s_key;
                OP_SET_ENABLE: touch_disabled_reg <= !s_enable;
                default: begin
                end
            endcase
        end
    end

    // sequencer: one slot result per cycle into the read stage, while the read stage can take it
    logic        s1_adv;
    logic        s1_load;
    result_t     s1_next;
    logic [2:0]  info_idx;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [11:0] y_raw;
    logic        slot_is_valid;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s1_load  = job_active_reg && (!s1_valid_reg || s1_adv);
    assign info_idx = 3'(INFO_SHIFT) + 3'(slot_reg);
    assign b0       = job_rec_reg[rec_reg][0];
    assign b1       = job_rec_reg[rec_reg][1];
    assign b2       = job_rec_reg[rec_reg][2];
    assign y_raw    = {b0[3:0], b2};
    assign slot_is_valid = job_kind_reg == KIND_CONTACT && job_info_reg[info_idx];

    always_comb begin
        s1_next               = '0;
        s1_next.kind          = job_kind_reg;
        s1_next.touch_enabled = job_en_reg;
        s1_next.last_result   = 1'b1;
        if (job_kind_reg == KIND_CONTACT) begin
            s1_next.slot          = 3'(slot_reg);
            s1_next.contact_valid = slot_is_valid;
            s1_next.finger_count  = job_cnt_reg;
            s1_next.last_result   = slot_reg == LAST_IDX;
            if (slot_is_valid) begin
                s1_next.pos_x  = {b0[7:4], b1};
                s1_next.pos_y  = (y_raw > max_y_reg) ? 12'd0 : max_y_reg - y_raw;
                s1_next.button = job_info_reg[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_active_reg <= 1'b0;
        end else if (s_acc && new_job) begin
            job_active_reg <= 1'b1;
        end else if (s1_load && (job_kind_reg != KIND_CONTACT || slot_reg == LAST_IDX)) begin
            job_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && new_job) begin
            job_kind_reg <= new_kind;
            job_en_reg   <= !touch_disabled_reg;
            job_info_reg <= info_fin;
            job_cnt_reg  <= cnt_fin;
            job_rec_reg  <= rec_fin;
            slot_reg     <= '0;
            rec_reg      <= '0;
        end else if (s1_load) begin
            slot_reg <= slot_reg + 1'b1;
            if (slot_is_valid) begin
                rec_reg <= rec_reg + 1'b1;
            end
        end
    end

    // read stage with held-position read-modify-write
    logic             held_wr;
    logic [IDX_W-1:0] held_wr_idx;
    logic [23:0]      held_wr_data;
    logic [23:0]      held_now;
    result_t          out_next;

    assign held_wr      = s1_adv && s1_reg.kind == KIND_CONTACT && s1_reg.contact_valid;
    assign held_wr_idx  = s1_reg.slot[IDX_W-1:0];
    assign held_wr_data = {s1_reg.pos_x, s1_reg.pos_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_reg         <= s1_next;
            held_q_reg     <= held_mem[slot_reg];
            held_q_vld_reg <= held_vld_reg[slot_reg];
            // write-back to the entry being read lands in the same cycle
            fwd_hit_reg    <= held_wr && held_wr_idx == slot_reg;
            fwd_data_reg   <= held_wr_data;
        end
        if (held_wr) begin
            held_mem[held_wr_idx] <= held_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_vld_reg <= '0;
        end else if (held_wr) begin
            held_vld_reg[held_wr_idx] <= 1'b1;
        end
    end

    always_comb begin
        if (fwd_hit_reg) begin
            held_now = fwd_data_reg;
        end else if (held_q_vld_reg) begin
            held_now = held_q_reg;
        end else begin
            held_now = '0;
        end
        out_next = s1_reg;
        if (s1_reg.kind == KIND_CONTACT && !s1_reg.contact_valid) begin
            out_next.pos_x = held_now[23:12];
            out_next.pos_y = held_now[11:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_res_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg.touch_enabled, m_res_reg.finger_count,
                       m_res_reg.button, m_res_reg.pos_y, m_res_reg.pos_x,
                       m_res_reg.contact_valid, m_res_reg.slot};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last_result;

    // configuration port
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_id_reg <= RST_REPORT_ID;
            quiet_reg     <= RST_QUIET;
            max_y_reg     <= RST_MAX_Y;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_REPORT_ID:  report_id_reg <= pwdata[7:0];
                REG_QUIET_TIME: quiet_reg     <= pwdata;
                REG_MAX_Y:      max_y_reg     <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_REPORT_ID:  prdata = {56'd0, report_id_reg};
            REG_QUIET_TIME: prdata = quiet_reg;
            REG_MAX_Y:      prdata = {52'd0, max_y_reg};
            default:        prdata = '0;
        endcase
    end

endmodule
